@@ src/eul2q_pkg.sv @@
package eul2q_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 14;
  localparam int OUT_W        = FRAC_BITS + 2;
  localparam int NANG         = 3;
  localparam int TERMS        = 12;
  localparam int XW           = 31;
  localparam int TW           = 32;
  localparam int SW           = 34;
  localparam int VW           = 32;
  localparam int MW           = 31;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;

  localparam int ANG_HEADING = 0;
  localparam int ANG_PITCH   = 1;
  localparam int ANG_BANK    = 2;

endpackage

@@ src/euler_to_quaternion.sv @@
// Heading-pitch-bank to unit quaternion converter.
// Input channel: heading, pitch and bank binary angles (2^16 counts per
// turn) qualified by in_valid; the word is taken on a clock edge with
// in_valid high and in_stall low.
// Output channel: quat_w/x/y/z in signed Q2.14, saturated to +-1.0,
// qualified by out_valid; the word is taken when out_stall is low.
// Pipeline of 41 register stages: input register, angle scaling, square,
// 11 Taylor terms of three stages each, quadrant map, pair product,
// triple product and sum stages, output rounding.
// Throughput: one word per cycle; every stage holds a valid bit and
// the whole pipeline advances together. Each Taylor term has, per angle,
// two 32x32 multiplies, two reciprocal multiplies and compare-subtract fix-ups.
// When the receiver stalls a valid output, the pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Bubbles are not squeezed out during a stall.
// Reset clears all valid bits; payload registers are not reset.
module euler_to_quaternion
  import eul2q_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ANGLE_BITS-1:0]    heading,
  input  logic [ANGLE_BITS-1:0]    pitch,
  input  logic [ANGLE_BITS-1:0]    bank,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  quat_w,
  output logic signed [OUT_W-1:0]  quat_x,
  output logic signed [OUT_W-1:0]  quat_y,
  output logic signed [OUT_W-1:0]  quat_z
);

  localparam int RW = ANGLE_BITS - 1;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // input register
  logic                  v0;
  logic [ANGLE_BITS-1:0] ang0 [NANG];

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ang0[ANG_HEADING] <= heading;
      ang0[ANG_PITCH]   <= pitch;
      ang0[ANG_BANK]    <= bank;
    end
  end

  // angle to radians, Q1.30
  logic          v1;
  logic [XW-1:0] x1   [NANG];
  logic          quad1 [NANG];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= v0;
  end
  always_ff @(posedge clk) begin
    logic [RW+XW-1:0] prod;
    if (adv) begin
      for (int i = 0; i < NANG; i++) begin
        prod = RW'(ang0[i][RW-1:0]) * (RW+XW)'(HALF_PI_Q30);
        prod = prod + ((RW+XW)'(1) << (RW - 1));
        x1[i]    <= XW'(prod >> RW);
        quad1[i] <= ang0[i][ANGLE_BITS-1];
      end
    end
  end

  // series registers, index 0 is the seed
  logic                 tv   [TERMS];
  logic [TW-1:0]        ts_q [TERMS][NANG];
  logic [TW-1:0]        tc_q [TERMS][NANG];
  logic [TW-1:0]        x2_q [TERMS][NANG];
  logic signed [SW-1:0] ss_q [TERMS][NANG];
  logic signed [SW-1:0] cs_q [TERMS][NANG];
  logic                 qd_q [TERMS][NANG];

  always_ff @(posedge clk) begin
    if (rst) tv[0] <= 1'b0;
    else if (adv) tv[0] <= v1;
  end
  always_ff @(posedge clk) begin
    logic [2*XW-1:0] sq;
    if (adv) begin
      for (int i = 0; i < NANG; i++) begin
        sq = x1[i] * x1[i];
        x2_q[0][i] <= TW'(sq >> 30);
        ts_q[0][i] <= TW'(x1[i]);
        tc_q[0][i] <= TW'(ONE_Q30);
        ss_q[0][i] <= SW'(x1[i]);
        cs_q[0][i] <= SW'(ONE_Q30);
        qd_q[0][i] <= quad1[i];
      end
    end
  end

  for (genvar k = 1; k < TERMS; k++) begin : g_term
    localparam int DS = (2 * k) * (2 * k + 1);
    localparam int DC = (2 * k - 1) * (2 * k);
    localparam int LS = $clog2(DS);
    localparam int LC = $clog2(DC);
    localparam logic [32:0] MS = 33'((64'd1 << (32 + LS)) / DS);
    localparam logic [32:0] MC = 33'((64'd1 << (32 + LC)) / DC);

    logic                 va, vb;
    logic [2*TW-1:0]      ps [NANG];
    logic [2*TW-1:0]      pc [NANG];
    logic [TW-1:0]        x2a [NANG];
    logic signed [SW-1:0] ssa [NANG];
    logic signed [SW-1:0] csa [NANG];
    logic                 qda [NANG];
    logic [TW-1:0]        ns [NANG];
    logic [TW-1:0]        nc [NANG];
    logic [TW+32:0]       qs [NANG];
    logic [TW+32:0]       qc [NANG];
    logic [TW-1:0]        x2b [NANG];
    logic signed [SW-1:0] ssb [NANG];
    logic signed [SW-1:0] csb [NANG];
    logic                 qdb [NANG];

    always_ff @(posedge clk) begin
      if (rst) begin
        va        <= 1'b0;
        vb        <= 1'b0;
        tv[k]     <= 1'b0;
      end else if (adv) begin
        va        <= tv[k-1];
        vb        <= va;
        tv[k]     <= vb;
      end
    end

    // term times x^2
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < NANG; i++) begin
          ps[i]  <= ts_q[k-1][i] * x2_q[k-1][i];
          pc[i]  <= tc_q[k-1][i] * x2_q[k-1][i];
          x2a[i] <= x2_q[k-1][i];
          ssa[i] <= ss_q[k-1][i];
          csa[i] <= cs_q[k-1][i];
          qda[i] <= qd_q[k-1][i];
        end
      end
    end

    // reciprocal multiply
    always_ff @(posedge clk) begin
      logic [TW-1:0] n_s, n_c;
      if (adv) begin
        for (int i = 0; i < NANG; i++) begin
          n_s = ps[i][TW+29:30];
          n_c = pc[i][TW+29:30];
          ns[i]  <= n_s;
          nc[i]  <= n_c;
          qs[i]  <= n_s * MS;
          qc[i]  <= n_c * MC;
          x2b[i] <= x2a[i];
          ssb[i] <= ssa[i];
          csb[i] <= csa[i];
          qdb[i] <= qda[i];
        end
      end
    end

    // quotient fix-up and accumulate
    always_ff @(posedge clk) begin
      logic [TW-1:0] q_s, q_c;
      logic [TW+9:0] r_s, r_c;
      if (adv) begin
        for (int i = 0; i < NANG; i++) begin
          q_s = TW'(qs[i] >> (32 + LS));
          q_c = TW'(qc[i] >> (32 + LC));
          r_s = (TW+10)'(ns[i]) - (TW+10)'(q_s) * (TW+10)'(DS);
          r_c = (TW+10)'(nc[i]) - (TW+10)'(q_c) * (TW+10)'(DC);
          if (r_s >= (TW+10)'(DS)) q_s = q_s + TW'(1);
          if (r_c >= (TW+10)'(DC)) q_c = q_c + TW'(1);
          ts_q[k][i] <= q_s;
          tc_q[k][i] <= q_c;
          x2_q[k][i] <= x2b[i];
          qd_q[k][i] <= qdb[i];
          if (k % 2 == 1) begin
            ss_q[k][i] <= ssb[i] - SW'(q_s);
            cs_q[k][i] <= csb[i] - SW'(q_c);
          end else begin
            ss_q[k][i] <= ssb[i] + SW'(q_s);
            cs_q[k][i] <= csb[i] + SW'(q_c);
          end
        end
      end
    end
  end

  // clamp and quadrant map
  logic                 vq;
  logic signed [VW-1:0] sv [NANG];
  logic signed [VW-1:0] cv [NANG];

  always_ff @(posedge clk) begin
    if (rst) vq <= 1'b0;
    else if (adv) vq <= tv[TERMS-1];
  end
  always_ff @(posedge clk) begin
    logic signed [VW-1:0] s_c, c_c;
    if (adv) begin
      for (int i = 0; i < NANG; i++) begin
        if (ss_q[TERMS-1][i] < 0) s_c = '0;
        else if (ss_q[TERMS-1][i] > SW'(ONE_Q30)) s_c = VW'(ONE_Q30);
        else s_c = VW'(ss_q[TERMS-1][i]);
        if (cs_q[TERMS-1][i] < 0) c_c = '0;
        else if (cs_q[TERMS-1][i] > SW'(ONE_Q30)) c_c = VW'(ONE_Q30);
        else c_c = VW'(cs_q[TERMS-1][i]);
        if (qd_q[TERMS-1][i]) begin
          sv[i] <= c_c;
          cv[i] <= -s_c;
        end else begin
          sv[i] <= s_c;
          cv[i] <= c_c;
        end
      end
    end
  end

  // pair products: ch*cp, sh*sp, ch*sp, sh*cp
  logic            vp1;
  logic [2*MW-1:0] pm  [4];
  logic            pn  [4];
  logic [MW-1:0]   bm  [2];
  logic            bn  [2];

  function automatic logic [MW-1:0] mag(input logic signed [VW-1:0] v);
    logic [VW-1:0] a;
    a = v[VW-1] ? VW'(-v) : VW'(v);
    return a[MW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vp1 <= 1'b0;
    else if (adv) vp1 <= vq;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pm[0] <= mag(cv[ANG_HEADING]) * mag(cv[ANG_PITCH]);
      pn[0] <= cv[ANG_HEADING][VW-1] ^ cv[ANG_PITCH][VW-1];
      pm[1] <= mag(sv[ANG_HEADING]) * mag(sv[ANG_PITCH]);
      pn[1] <= sv[ANG_HEADING][VW-1] ^ sv[ANG_PITCH][VW-1];
      pm[2] <= mag(cv[ANG_HEADING]) * mag(sv[ANG_PITCH]);
      pn[2] <= cv[ANG_HEADING][VW-1] ^ sv[ANG_PITCH][VW-1];
      pm[3] <= mag(sv[ANG_HEADING]) * mag(cv[ANG_PITCH]);
      pn[3] <= sv[ANG_HEADING][VW-1] ^ cv[ANG_PITCH][VW-1];
      bm[0] <= mag(cv[ANG_BANK]);
      bn[0] <= cv[ANG_BANK][VW-1];
      bm[1] <= mag(sv[ANG_BANK]);
      bn[1] <= sv[ANG_BANK][VW-1];
    end
  end

  // triple products; bank term: 0 = cb, 1 = sb
  logic            vp2;
  logic [2*MW-1:0] tm [8];
  logic            tn [8];

  function automatic logic [MW-1:0] rnd(input logic [2*MW-1:0] p);
    logic [2*MW-1:0] t;
    t = p + (2*MW)'(1 << 29);
    return MW'(t >> 30);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vp2 <= 1'b0;
    else if (adv) vp2 <= vp1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      tm[0] <= rnd(pm[0]) * bm[0];  tn[0] <= pn[0] ^ bn[0];
      tm[1] <= rnd(pm[1]) * bm[1];  tn[1] <= pn[1] ^ bn[1];
      tm[2] <= rnd(pm[2]) * bm[0];  tn[2] <= pn[2] ^ bn[0];
      tm[3] <= rnd(pm[3]) * bm[1];  tn[3] <= pn[3] ^ bn[1];
      tm[4] <= rnd(pm[3]) * bm[0];  tn[4] <= pn[3] ^ bn[0];
      tm[5] <= rnd(pm[2]) * bm[1];  tn[5] <= pn[2] ^ bn[1];
      tm[6] <= rnd(pm[0]) * bm[1];  tn[6] <= pn[0] ^ bn[1];
      tm[7] <= rnd(pm[1]) * bm[0];  tn[7] <= pn[1] ^ bn[0];
    end
  end

  // sums
  logic                   vp3;
  logic signed [VW:0]     qsum [4];

  function automatic logic signed [VW:0] sval(input logic [2*MW-1:0] p, input logic n);
    logic signed [VW:0] m;
    m = (VW+1)'(rnd(p));
    return n ? -m : m;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vp3 <= 1'b0;
    else if (adv) vp3 <= vp2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      qsum[0] <= sval(tm[0], tn[0]) + sval(tm[1], tn[1]);
      qsum[1] <= sval(tm[2], tn[2]) + sval(tm[3], tn[3]);
      qsum[2] <= sval(tm[4], tn[4]) - sval(tm[5], tn[5]);
      qsum[3] <= sval(tm[6], tn[6]) - sval(tm[7], tn[7]);
    end
  end

  // output rounding and saturation
  localparam int SH = 30 - FRAC_BITS;

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [VW:0] v);
    logic [VW:0] m;
    m = v[VW] ? (VW+1)'(-v) : (VW+1)'(v);
    if (SH > 0) m = (m + ((VW+1)'(1) << (SH > 0 ? SH - 1 : 0))) >> SH;
    if (m > ((VW+1)'(1) << FRAC_BITS)) m = (VW+1)'(1) << FRAC_BITS;
    return v[VW] ? OUT_W'(-m) : OUT_W'(m);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vp3;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      quat_w <= to_out(qsum[0]);
      quat_x <= to_out(qsum[1]);
      quat_y <= to_out(qsum[2]);
      quat_z <= to_out(qsum[3]);
    end
  end

endmodule

@@ bench/euler_to_quaternion_test.sv @@
`timescale 1ns / 100ps

module euler_to_quaternion_test;
  import eul2q_pkg::*;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] hdg;
    logic [ANGLE_BITS-1:0] pit;
    logic [ANGLE_BITS-1:0] bnk;
  } attitude_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] w;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } quat_t;

  localparam int WATCHDOG    = 20000;
  localparam int LATENCY     = 41;
  localparam int HOLD_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ANGLE_BITS-1:0] heading = '0, pitch = '0, bank = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] quat_w, quat_x, quat_y, quat_z;

  attitude_t pending_words[$];
  quat_t     expected_quats[$];
  int        errors = 0;
  int        words_in = 0, words_out = 0;
  int        send_idle_pct = 0, stall_pct = 0;
  bit        hold_req = 1'b0;
  bit        hold_recv = 1'b0;
  int        hold_count = 0;
  bit        hold_send = 1'b0;
  int        quiet_cycles = 0;

  euler_to_quaternion DUT (.*);

  always #5 clk = ~clk;

  function automatic longint fx_mul(longint a, longint b);
    longint ua, ub, p;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = (ua * ub + (64'sd1 <<< 29)) >>> 30;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v < 0) return 0;
    if (v > 64'sd1073741824) return 64'sd1073741824;
    return v;
  endfunction

  function automatic void half_angle_trig(input logic [ANGLE_BITS-1:0] ang,
                                          output longint s, output longint c);
    logic [31:0] turn;
    logic [63:0] r, x, x2, ts, tc, k;
    longint ss, cs;
    turn = {16'd0, ang} << (31 - ANGLE_BITS);
    r = {34'd0, turn[29:0]};
    x = (r * 64'd1686629713 + (64'd1 << 29)) >> 30;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1073741824;
    ss = x;
    cs = 64'sd1073741824;
    for (int n = 1; n < TERMS; n++) begin
      k = n;
      ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
      if (n & 1) begin
        ss -= longint'(ts);
        cs -= longint'(tc);
      end else begin
        ss += longint'(ts);
        cs += longint'(tc);
      end
    end
    ss = unit_clamp(ss);
    cs = unit_clamp(cs);
    case (turn[31:30])
      2'd0: begin s = ss; c = cs; end
      2'd1: begin s = cs; c = -ss; end
      2'd2: begin s = -ss; c = -cs; end
      default: begin s = -cs; c = ss; end
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] round_q14(longint v);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    if (m > (64'sd1 <<< FRAC_BITS)) m = 64'sd1 <<< FRAC_BITS;
    return OUT_W'(v < 0 ? -m : m);
  endfunction

  function automatic quat_t hpb_to_quat(attitude_t a);
    longint sh, ch, sp, cp, sb, cb;
    quat_t q;
    half_angle_trig(a.hdg, sh, ch);
    half_angle_trig(a.pit, sp, cp);
    half_angle_trig(a.bnk, sb, cb);
    q.w = round_q14(fx_mul(fx_mul(ch, cp), cb) + fx_mul(fx_mul(sh, sp), sb));
    q.x = round_q14(fx_mul(fx_mul(ch, sp), cb) + fx_mul(fx_mul(sh, cp), sb));
    q.y = round_q14(fx_mul(fx_mul(sh, cp), cb) - fx_mul(fx_mul(ch, sp), sb));
    q.z = round_q14(fx_mul(fx_mul(ch, cp), sb) - fx_mul(fx_mul(sh, sp), cb));
    return q;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch word %0d %s: got %0d expected %0d", words_out, what, got, want);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'(16'h4000 * $urandom_range(0, 3));
      1: return 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 4) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      hold_recv <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      hold_recv <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_quats.push_back(hpb_to_quat({heading, pitch, bank}));
        words_in++;
      end
      if ((in_valid && in_stall) ||
          (pending_words.size() == 0 && in_valid && in_stall)) begin
      end else if (pending_words.size() > 0 && !hold_send &&
                   $urandom_range(1, 100) > send_idle_pct) begin
        attitude_t a;
        a = pending_words.pop_front();
        in_valid <= 1'b1;
        heading <= a.hdg;
        pitch <= a.pit;
        bank <= a.bnk;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        quat_t q;
        words_out++;
        if (expected_quats.size() == 0) begin
          report_mismatch("unexpected", 0, 0);
        end else begin
          q = expected_quats.pop_front();
          if (quat_w !== q.w) report_mismatch("quat_w", quat_w, q.w);
          if (quat_x !== q.x) report_mismatch("quat_x", quat_x, q.x);
          if (quat_y !== q.y) report_mismatch("quat_y", quat_y, q.y);
          if (quat_z !== q.z) report_mismatch("quat_z", quat_z, q.z);
        end
      end
      out_stall <= hold_recv || ($urandom_range(1, 100) <= stall_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog expired");
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_quats.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [15:0] corners[8];
    corners = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                16'h3FFF, 16'h7FFF, 16'h0001};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 8; i++)
      pending_words.push_back({corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]});
    for (int i = 0; i < 8; i++)
      pending_words.push_back({corners[i], corners[i], corners[i]});
    pending_words.push_back({16'hAAAA, 16'h5555, 16'hAAAA});
    pending_words.push_back({16'h5555, 16'hAAAA, 16'h5555});
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 71 : 16) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 71 : 16) : 0;
      for (int i = 0; i < 446; i++)
        pending_words.push_back({rand_angle(), rand_angle(), rand_angle()});
      if (ph == 0) hold_req = 1'b1;
      drain();
      hold_send = 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      hold_send = 1'b0;
    end
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (LATENCY + 10) @(posedge clk);

    $display("converted %0d attitude words to quaternions, %0d results checked",
             words_in, words_out);
    $display("phases: back to back, sparse input, heavy stall, mixed, long hold-off");
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
